// ===== rtl/fcst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcst_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // One received check message
    typedef struct packed {
        logic [31:0] source_addr;
        logic [31:0] seq_num;
        logic [63:0] digest;
        logic [7:0]  hops_left;
        logic [31:0] neighbour_addr;
    } t_in;

    // One decision beat
    typedef struct packed {
        logic        do_forward;
        logic [7:0]  forward_hops;
        logic        want_interest;
        logic [31:0] interest_dest;
        logic        table_full;
    } t_out;

    // Search token handed from cell to cell
    typedef struct packed {
        logic        vld;
        logic        hit;
        logic        free;
        logic        fwd_vld;
        logic [31:0] fwd_seq;
        logic        seen_vld;
        logic [31:0] seen_seq;
    } t_scan;

    // Update command broadcast to the cells
    typedef struct packed {
        logic        en;
        logic        alloc;
        logic        set_fwd;
        logic        set_seen;
        logic [31:0] seq;
    } t_wr;

endpackage

`default_nettype wire

// ===== rtl/fcst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcst_cell
    import fcst_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [31:0]       i_src,
    input  wire t_scan       i_scan,
    input  wire [IDX_W-1:0]  i_hit_idx,
    input  wire [IDX_W-1:0]  i_free_idx,
    output t_scan            o_scan,
    output logic [IDX_W-1:0] o_hit_idx,
    output logic [IDX_W-1:0] o_free_idx,
    input  wire t_wr         i_wr,
    input  wire [IDX_W-1:0]  i_wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             r_used;
    logic [31:0]      r_tag;
    logic             r_seen_vld;
    logic [31:0]      r_seen_seq;
    logic             r_fwd_vld;
    logic [31:0]      r_fwd_seq;
    t_scan            r_scan;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_free_idx;

    t_scan            n_scan;
    logic [IDX_W-1:0] n_hit_idx;
    logic [IDX_W-1:0] n_free_idx;
    logic             w_sel;

    // Compare against this entry as the token passes
    always_comb begin
        n_scan     = i_scan;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        if (i_scan.vld && !i_scan.hit) begin
            if (r_used && (r_tag == i_src)) begin
                n_scan.hit      = 1'b1;
                n_scan.fwd_vld  = r_fwd_vld;
                n_scan.fwd_seq  = r_fwd_seq;
                n_scan.seen_vld = r_seen_vld;
                n_scan.seen_seq = r_seen_seq;
                n_hit_idx       = MY_IDX;
            end else if (!r_used && !i_scan.free) begin
                n_scan.free = 1'b1;
                n_free_idx  = MY_IDX;
            end
        end
    end

    assign w_sel = i_wr.en && (i_wr_idx == MY_IDX);

    // Advance the token and update the valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= '0;
            r_used     <= 1'b0;
            r_seen_vld <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_scan <= n_scan;
            if (w_sel) begin
                r_used <= 1'b1;
                if (i_wr.set_fwd) begin
                    r_fwd_vld <= 1'b1;
                end else if (i_wr.alloc) begin
                    r_fwd_vld <= 1'b0;
                end
                if (i_wr.set_seen) begin
                    r_seen_vld <= 1'b1;
                end else if (i_wr.alloc) begin
                    r_seen_vld <= 1'b0;
                end
            end
        end
    end

    // Hold entry payload and token indexes
    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (w_sel) begin
            r_tag <= i_src;
            if (i_wr.set_fwd) begin
                r_fwd_seq <= i_wr.seq;
            end
            if (i_wr.set_seen) begin
                r_seen_seq <= i_wr.seq;
            end
        end
    end

    assign o_scan     = r_scan;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

`default_nettype wire

// ===== rtl/flood_check_suppression_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Beat
// in        input      i_in_valid/o_in_stall  t_in (one check message)
// out       output     o_out_valid/i_out_stall t_out (one decision)
// cfg       input      i_cfg_wr_en            i_cfg_wr_data (local digest)
//
// For each message a search token walks the row of cells one entry per cycle,
// then the resolve step decides and writes back to the table.
// The decision beat is registered when the resolve step fires.
// Reset clears all valid marks at once; no clearing pass is needed.
// A stalled output holds the resolve step; the next message waits for it.

module flood_check_suppression_table_unit
    import fcst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire t_in   i_in,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out       o_out,
    input  wire        i_cfg_wr_en,
    input  wire [63:0] i_cfg_wr_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_in              r_q;
    logic             r_start;
    t_scan            r_res;
    logic [IDX_W-1:0] r_res_hit_idx;
    logic [IDX_W-1:0] r_res_free_idx;
    logic [63:0]      r_local_digest;
    logic             r_out_valid;
    t_out             r_out;

    t_scan            w_scan     [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] w_hit_idx  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] w_free_idx [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_tok;

    logic             w_in_acc;
    logic             w_fire;
    logic             w_full;
    logic             w_alloc;
    logic [IDX_W-1:0] w_idx;
    logic             w_fv;
    logic             w_sv;
    logic             w_fwd_new;
    logic             w_seen_new;
    logic             w_do_fwd;
    logic             w_interest;
    t_wr              w_wr;
    t_out             w_out;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Inject an empty token at the head of the row
    always_comb begin
        w_scan[0]     = '0;
        w_scan[0].vld = r_start;
        w_hit_idx[0]  = '0;
        w_free_idx[0] = '0;
    end

    // Row of table cells
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        fcst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_src      (r_q.source_addr),
            .i_scan     (w_scan[k]),
            .i_hit_idx  (w_hit_idx[k]),
            .i_free_idx (w_free_idx[k]),
            .o_scan     (w_scan[k+1]),
            .o_hit_idx  (w_hit_idx[k+1]),
            .o_free_idx (w_free_idx[k+1]),
            .i_wr       (w_wr),
            .i_wr_idx   (w_idx)
        );
        assign w_tok[k] = w_scan[k+1].vld;
    end

    // Decide from the search result
    always_comb begin
        w_full     = !r_res.hit && !r_res.free;
        w_alloc    = !r_res.hit && r_res.free;
        w_idx      = r_res.hit ? r_res_hit_idx : r_res_free_idx;
        w_fv       = r_res.hit && r_res.fwd_vld;
        w_sv       = r_res.hit && r_res.seen_vld;
        w_fwd_new  = !w_fv || (r_q.seq_num > r_res.fwd_seq);
        w_seen_new = !w_sv || (r_res.seen_seq < r_q.seq_num);
        w_do_fwd   = (r_q.hops_left > 8'd1) && w_fwd_new;
        w_interest = w_seen_new && (r_q.digest != r_local_digest);
        w_fire     = (r_state == ST_RESOLVE) && (!r_out_valid || !i_out_stall);

        w_wr.en       = w_fire && !w_full;
        w_wr.alloc    = w_alloc;
        w_wr.set_fwd  = w_do_fwd;
        w_wr.set_seen = w_seen_new;
        w_wr.seq      = r_q.seq_num;

        w_out.do_forward    = w_do_fwd;
        w_out.forward_hops  = w_do_fwd ? 8'(r_q.hops_left - 8'd1) : 8'd0;
        w_out.want_interest = w_interest;
        w_out.interest_dest = w_interest ? r_q.neighbour_addr : 32'd0;
        w_out.table_full    = w_full;
    end

    // Sequence one message at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan[TABLE_ENTRIES].vld) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_local_digest <= 64'd0;
        end else begin
            r_state <= n_state;
            r_start <= w_in_acc;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_local_digest <= i_cfg_wr_data;
            end
        end
    end

    // Hold message, search result and output beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_q <= i_in;
        end
        if ((r_state == ST_SCAN) && w_scan[TABLE_ENTRIES].vld) begin
            r_res          <= w_scan[TABLE_ENTRIES];
            r_res_hit_idx  <= w_hit_idx[TABLE_ENTRIES];
            r_res_free_idx <= w_free_idx[TABLE_ENTRIES];
        end
        if (w_fire) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Only one search token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one search token in the cell row");

    // Token reaches the end only while scanning
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[TABLE_ENTRIES].vld |-> (r_state == ST_SCAN))
        else $error("search token left the row outside a scan");

    // Accepted message starts a scan
    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_SCAN) && r_start)
        else $error("accepted message did not start a scan");

    // New output beat only from the resolve step
    a_out_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESOLVE))
        else $error("output beat raised outside resolve");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fcst_pkg::*;

    localparam int TBL_N      = TABLE_ENTRIES_DEF;
    localparam int POOL_N     = 20;
    localparam int PHASE_MSGS = 300;
    localparam int LONG_HOLD  = 250;
    localparam int WDOG_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_beat;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;

    flood_check_suppression_table_unit #(
        .TABLE_ENTRIES(TBL_N)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_beat),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the origin table and the local digest
    bit [31:0]   org_tag  [TBL_N];
    bit          org_used [TBL_N];
    bit          seen_ok  [TBL_N];
    bit [31:0]   seen_hi  [TBL_N];
    bit          fwd_ok   [TBL_N];
    bit [31:0]   fwd_last [TBL_N];
    logic [63:0] own_digest = '0;

    t_in  pending_msgs[$];
    t_out decision_fifo[$];
    t_out got_want;

    // Stimulus bookkeeping: origin pool and highest sequence issued per origin
    bit [31:0] pool_addr [POOL_N];
    bit [31:0] pool_seq  [POOL_N];

    int  n_queued = 0;
    int  n_taken = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_fwd = 0;
    int  n_interest = 0;
    int  n_full = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  quiet_cycles = 0;
    bit  idle_bursts = 1'b1;
    bit  long_hold_done = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Decide one message against the mirrored table and update it
    function automatic t_out judge_check(t_in m);
        int   slot;
        int   spare;
        bit   no_room;
        bit   fwd_new;
        bit   seen_new;
        t_out r;
        slot = -1;
        spare = -1;
        no_room = 1'b0;
        r = '0;
        for (int e = 0; e < TBL_N; e++) begin
            if (org_used[e]) begin
                if (slot < 0 && org_tag[e] == m.source_addr) slot = e;
            end else if (spare < 0) begin
                spare = e;
            end
        end
        // claim the lowest free entry for a new origin
        if (slot < 0) begin
            if (spare >= 0) begin
                slot = spare;
                org_used[slot] = 1'b1;
                org_tag[slot] = m.source_addr;
                seen_ok[slot] = 1'b0;
                fwd_ok[slot] = 1'b0;
            end else begin
                no_room = 1'b1;
            end
        end
        fwd_new  = (slot < 0) || !fwd_ok[slot] || (m.seq_num > fwd_last[slot]);
        seen_new = (slot < 0) || !seen_ok[slot] || (m.seq_num > seen_hi[slot]);
        if (m.hops_left > 8'd1 && fwd_new) begin
            r.do_forward = 1'b1;
            r.forward_hops = m.hops_left - 8'd1;
            if (slot >= 0) begin
                fwd_ok[slot] = 1'b1;
                fwd_last[slot] = m.seq_num;
            end
        end
        if (seen_new) begin
            if (slot >= 0) begin
                seen_ok[slot] = 1'b1;
                seen_hi[slot] = m.seq_num;
            end
            if (m.digest != own_digest) begin
                r.want_interest = 1'b1;
                r.interest_dest = m.neighbour_addr;
            end
        end
        r.table_full = no_room;
        return r;
    endfunction

    task automatic queue_msg(bit [31:0] src, bit [31:0] seq, bit [63:0] dig,
                             bit [7:0] hops, bit [31:0] nbr);
        t_in m;
        m.source_addr = src;
        m.seq_num = seq;
        m.digest = dig;
        m.hops_left = hops;
        m.neighbour_addr = nbr;
        pending_msgs.insert(pending_msgs.size(), m);
        n_queued++;
    endtask

    // Mostly known origins with nearby sequences, some fresh origins
    task automatic queue_random_msg();
        int        idx;
        int        pick;
        int        hsel;
        bit [31:0] src;
        bit [31:0] seq;
        bit [63:0] dig;
        bit [7:0]  hops;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) begin
            idx = $urandom_range(0, POOL_N - 1);
            src = pool_addr[idx];
            if (pick < 45)      seq = pool_seq[idx] + $urandom_range(1, 4);
            else if (pick < 60) seq = pool_seq[idx];
            else if (pick < 75) seq = pool_seq[idx] - $urandom_range(1, 4);
            else if (pick < 85) seq = pool_seq[idx] + $urandom_range(5, 100000);
            else                seq = $urandom;
            if (seq > pool_seq[idx]) pool_seq[idx] = seq;
        end else begin
            src = $urandom;
            if (pick < 10)      seq = '0;
            else if (pick < 20) seq = '1;
            else                seq = $urandom;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dig = own_digest;
            5:             dig = '1;
            default:       dig = {$urandom, $urandom};
        endcase
        hsel = $urandom_range(0, 9);
        case (hsel)
            0:       hops = 8'd0;
            1:       hops = 8'd1;
            2:       hops = 8'd2;
            3:       hops = 8'd255;
            default: hops = 8'($urandom_range(0, 255));
        endcase
        queue_msg(src, seq, dig, hops, $urandom);
    endtask

    // Wait until every decision is back, then let the write-back settle
    task automatic wait_drained();
        while (n_taken != n_queued || decision_fifo.size() != 0) @(posedge i_clk);
        repeat (TBL_N + 3) @(posedge i_clk);
    endtask

    task automatic load_digest(logic [63:0] v);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        own_digest = v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    // Sender: offer queued messages, hold a stalled beat, idle in bursts
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                decision_fifo.insert(decision_fifo.size(), judge_check(in_beat));
                n_fwd += int'(decision_fifo[$].do_forward);
                n_interest += int'(decision_fifo[$].want_interest);
                n_full += int'(decision_fifo[$].table_full);
                n_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap--;
                end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
                    in_valid <= 1'b0;
                    in_gap = $urandom_range(0, 10);
                end else if (pending_msgs.size() != 0) begin
                    in_valid <= 1'b1;
                    in_beat <= pending_msgs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each decision beat, stall in bursts and once for long
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (decision_fifo.size() == 0) begin
                    $error("decision beat with no message outstanding");
                    n_errors++;
                end else begin
                    got_want = decision_fifo.pop_front();
                    check_field("do_forward", 64'(got_want.do_forward),
                                64'(out_beat.do_forward));
                    check_field("forward_hops", 64'(got_want.forward_hops),
                                64'(out_beat.forward_hops));
                    check_field("want_interest", 64'(got_want.want_interest),
                                64'(out_beat.want_interest));
                    check_field("interest_dest", 64'(got_want.interest_dest),
                                64'(out_beat.interest_dest));
                    check_field("table_full", 64'(got_want.table_full),
                                64'(out_beat.table_full));
                end
                n_checked++;
            end
            if (!long_hold_done && n_checked == 150) begin
                out_stall <= 1'b1;
                out_gap = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (out_gap > 0) begin
                out_stall <= 1'b1;
                out_gap--;
            end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                out_gap = $urandom_range(0, 10);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: abort after too many cycles with no beat moving
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        pool_addr[0] = '0;
        pool_addr[1] = '1;
        for (int i = 2; i < POOL_N; i++) pool_addr[i] = $urandom;
        pool_seq[0] = 32'd1;
        pool_seq[1] = '1;
        for (int i = 2; i < POOL_N; i++) pool_seq[i] = $urandom_range(0, 1000);

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: new origin, forwarding and seen records, small budgets
        queue_msg(pool_addr[0], 32'd0, 64'd0, 8'd0, 32'd0);
        queue_msg(pool_addr[0], 32'd0, '1, 8'd255, '1);
        queue_msg(pool_addr[0], 32'd0, '1, 8'd2, 32'h1234_5678);
        queue_msg(pool_addr[0], 32'd1, '1, 8'd1, 32'h8765_4321);
        queue_msg(pool_addr[0], 32'd1, '1, 8'd2, 32'h0000_0001);
        queue_msg(pool_addr[0], 32'd0, '1, 8'd3, 32'h8000_0000);
        queue_msg(pool_addr[1], '1, 64'd1, 8'd2, 32'hA5A5_A5A5);
        queue_msg(pool_addr[1], '1, 64'h8000_0000_0000_0000, 8'd255, 32'h5A5A_5A5A);
        queue_msg(pool_addr[1], 32'hFFFF_FFFE, 64'd0, 8'd4, 32'hFFFF_0000);
        // fill the remaining entries, then one origin with no room left
        for (int i = 2; i < TBL_N; i++) begin
            queue_msg(pool_addr[i], pool_seq[i], {$urandom, $urandom},
                      8'($urandom_range(0, 255)), $urandom);
        end
        queue_msg(pool_addr[TBL_N], 32'd7, '1, 8'd2, 32'hC3C3_C3C3);

        // Random phases, one digest setting each; the last one without idling
        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1:       load_digest('1);
                    3:       load_digest('0);
                    default: load_digest({$urandom, $urandom});
                endcase
            end
            if (p == 4) idle_bursts = 1'b0;
            for (int i = 0; i < PHASE_MSGS; i++) queue_random_msg();
        end

        wait_drained();
        if (decision_fifo.size() != 0) begin
            $error("%0d decisions never arrived", decision_fifo.size());
            n_errors++;
        end
        $display("ran %0d check messages under 5 digest settings with a full table",
                 n_taken);
        $display("decisions: %0d rebroadcasts, %0d interest replies, %0d table-full",
                 n_fwd, n_interest, n_full);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
